// ===== rtl/pid_pkg.sv =====
// ----------------------------------------------------------------------------
// pid_pkg
// Shared types, constants and saturating helpers of the fixed-point PID step.
// ----------------------------------------------------------------------------
package pid_pkg;

   localparam int GAIN_W    = 31;
   localparam int SUM_W     = 48;
   localparam int TIME_W    = 32;
   localparam int MODE_W    = 2;
   localparam int CSR_IDX_W = 3;

   localparam int DEFAULT_OUT_MAX = 255;
   localparam logic [TIME_W-1:0] DEFAULT_PERIOD = TIME_W'(100);

   typedef logic signed [SUM_W-1:0] sum_type;

   localparam logic signed [SUM_W:0] SAT_HI = {2'b00, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W:0] SAT_LO = -SAT_HI;
   localparam sum_type SUM_MAX = SAT_HI[SUM_W-1:0];

   typedef enum logic [MODE_W-1:0] {
      MODE_COMPUTE = 2'd0,
      MODE_START   = 2'd1,
      MODE_STOP    = 2'd2
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P        = 3'd0,
      CSR_GAIN_I        = 3'd1,
      CSR_GAIN_D        = 3'd2,
      CSR_P_ON_MEAS     = 3'd3,
      CSR_REVERSE       = 3'd4,
      CSR_OUT_MIN       = 3'd5,
      CSR_OUT_MAX       = 3'd6,
      CSR_SAMPLE_PERIOD = 3'd7
   } csr_index_type;

   function automatic sum_type sat_add(input sum_type a, input sum_type b);
      logic signed [SUM_W:0] s;
      s = (SUM_W+1)'(a) + (SUM_W+1)'(b);
      if (s > SAT_HI) begin
         return SAT_HI[SUM_W-1:0];
      end else if (s < SAT_LO) begin
         return SAT_LO[SUM_W-1:0];
      end
      return s[SUM_W-1:0];
   endfunction

   function automatic sum_type clamp(input sum_type x, input sum_type lo, input sum_type hi);
      sum_type y;
      y = (x < hi) ? x : hi;
      return (y > lo) ? y : lo;
   endfunction

endpackage

// ===== rtl/pid_term.sv =====
// ----------------------------------------------------------------------------
// pid_term
// Gain product: magnitude times unsigned gain, fraction dropped toward zero,
// saturated, sign restored and flipped for reverse action.
// ----------------------------------------------------------------------------
module pid_term #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic signed [DATA_WIDTH:0]   value,
   input  logic [pid_pkg::GAIN_W-1:0]  gain,
   input  logic                        reverse,
   output pid_pkg::sum_type            term_out
);
   import pid_pkg::*;

   localparam int MAG_W  = DATA_WIDTH + 1;
   localparam int PROD_W = MAG_W + GAIN_W;

   logic              negative;
   logic [MAG_W-1:0]  magnitude;
   logic [PROD_W-1:0] product;
   logic [PROD_W-1:0] shifted;
   sum_type           quotient;

   assign negative  = value[DATA_WIDTH];
   assign magnitude = negative ? MAG_W'(-value) : MAG_W'(value);
   assign product   = PROD_W'(magnitude) * PROD_W'(gain);
   assign shifted   = product >> FRAC_BITS;
   assign quotient  = (shifted > PROD_W'(SUM_MAX)) ? SUM_MAX : $signed(shifted[SUM_W-1:0]);
   assign term_out  = (negative ^ reverse) ? -quotient : quotient;

endmodule

// ===== rtl/pid_controller_step.sv =====
// ----------------------------------------------------------------------------
// pid_controller_step: a transaction passes the input register, then one pass of
// the three gain products and clamps into the result register that drives rsp_drive.
// Throughput one transaction per cycle unless a stalled output register holds off the input.
// Reset clears the loop state and loads default limits 0 .. 255.0, period 100.
// ----------------------------------------------------------------------------
module pid_controller_step #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_valid,
   output logic                                         req_ready,
   input  logic [pid_pkg::MODE_W-1:0]                   req_mode,
   input  logic signed [DATA_WIDTH-1:0]                 req_measurement,
   input  logic signed [DATA_WIDTH-1:0]                 req_setpoint,
   input  logic [pid_pkg::TIME_W-1:0]                   req_now_ms,
   input  logic signed [DATA_WIDTH-1:0]                 req_initial_output,
   output logic                                         rsp_valid,
   input  logic                                         rsp_ready,
   output logic signed [DATA_WIDTH-1:0]                 rsp_drive,
   input  logic                                         csr_we,
   input  logic [pid_pkg::CSR_IDX_W-1:0]                csr_index,
   input  logic [((DATA_WIDTH > 32) ? DATA_WIDTH : 32)-1:0] csr_wdata
);
   import pid_pkg::*;

   localparam sum_type OUT_MAX_RESET = sum_type'(DEFAULT_OUT_MAX) << FRAC_BITS;

   // configuration
   logic [GAIN_W-1:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic              p_on_meas_ff, reverse_ff;
   sum_type           out_min_ff, out_max_ff;
   logic [TIME_W-1:0] period_ff;

   // loop state
   logic                         running_ff, running_in;
   sum_type                      sum_ff, sum_in;
   logic signed [DATA_WIDTH-1:0] last_meas_ff, last_meas_in;
   logic [TIME_W-1:0]            last_time_ff, last_time_in;
   logic                         time_valid_ff, time_valid_in;

   // input register
   logic                         in_valid_ff;
   logic [MODE_W-1:0]            mode_ff;
   logic signed [DATA_WIDTH-1:0] meas_ff, sp_ff, init_ff;
   logic [TIME_W-1:0]            now_ff;

   // result register
   logic                         rsp_valid_ff;
   logic signed [DATA_WIDTH-1:0] drive_ff, drive_in;

   logic                         advance, fire;
   logic [TIME_W-1:0]            elapsed;
   logic signed [DATA_WIDTH:0]   err, delta, p_value;
   sum_type                      term_i, term_p, term_d;
   sum_type                      sum_s1, sum_s2, sum_s3, sum_s4, drive_full;
   sum_type                      csr_limit, min_new, max_new;
   logic                         limit_wr;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = drive_ff;

   assign elapsed = now_ff - last_time_ff;
   assign fire    = advance && (mode_ff == MODE_COMPUTE) && running_ff &&
                    (!time_valid_ff || (elapsed >= period_ff));

   assign err     = (DATA_WIDTH+1)'(sp_ff) - (DATA_WIDTH+1)'(meas_ff);
   assign delta   = (DATA_WIDTH+1)'(meas_ff) - (DATA_WIDTH+1)'(last_meas_ff);
   assign p_value = p_on_meas_ff ? delta : err;

   pid_term #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_term_i (
      .value(err), .gain(gain_i_ff), .reverse(reverse_ff), .term_out(term_i));
   pid_term #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_term_p (
      .value(p_value), .gain(gain_p_ff), .reverse(reverse_ff), .term_out(term_p));
   pid_term #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_term_d (
      .value(delta), .gain(gain_d_ff), .reverse(reverse_ff), .term_out(term_d));

   assign sum_s1     = sat_add(sum_ff, term_i);
   assign sum_s2     = sat_add(sum_s1, p_on_meas_ff ? -term_p : term_p);
   assign sum_s3     = clamp(sum_s2, out_min_ff, out_max_ff);
   assign sum_s4     = sat_add(sum_s3, -term_d);
   assign drive_full = clamp(sum_s4, out_min_ff, out_max_ff);
   assign drive_in   = drive_full[DATA_WIDTH-1:0];

   assign csr_limit = sum_type'($signed(csr_wdata[DATA_WIDTH-1:0]));
   assign limit_wr  = csr_we && ((csr_index == CSR_OUT_MIN) || (csr_index == CSR_OUT_MAX));
   assign min_new   = (csr_we && (csr_index == CSR_OUT_MIN)) ? csr_limit : out_min_ff;
   assign max_new   = (csr_we && (csr_index == CSR_OUT_MAX)) ? csr_limit : out_max_ff;

   always_comb begin
      running_in    = running_ff;
      sum_in        = sum_ff;
      last_meas_in  = last_meas_ff;
      last_time_in  = last_time_ff;
      time_valid_in = time_valid_ff;
      if (advance && (mode_ff == MODE_START)) begin
         sum_in       = clamp(sum_type'(init_ff), out_min_ff, out_max_ff);
         last_meas_in = meas_ff;
         running_in   = 1'b1;
      end else if (advance && (mode_ff == MODE_STOP)) begin
         running_in = 1'b0;
      end else if (fire) begin
         sum_in        = sum_s4;
         last_meas_in  = meas_ff;
         last_time_in  = now_ff;
         time_valid_in = 1'b1;
      end else if (limit_wr && running_ff && (min_new < max_new)) begin
         sum_in = clamp(sum_ff, min_new, max_new);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff    <= '0;
         gain_i_ff    <= '0;
         gain_d_ff    <= '0;
         p_on_meas_ff <= 1'b0;
         reverse_ff   <= 1'b0;
         out_min_ff   <= '0;
         out_max_ff   <= OUT_MAX_RESET;
         period_ff    <= DEFAULT_PERIOD;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GAIN_P:        gain_p_ff    <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN_I:        gain_i_ff    <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN_D:        gain_d_ff    <= csr_wdata[GAIN_W-1:0];
            CSR_P_ON_MEAS:     p_on_meas_ff <= csr_wdata[0];
            CSR_REVERSE:       reverse_ff   <= csr_wdata[0];
            CSR_OUT_MIN:       out_min_ff   <= csr_limit;
            CSR_OUT_MAX:       out_max_ff   <= csr_limit;
            CSR_SAMPLE_PERIOD: period_ff    <= csr_wdata[TIME_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff    <= 1'b0;
         sum_ff        <= '0;
         last_meas_ff  <= '0;
         last_time_ff  <= '0;
         time_valid_ff <= 1'b0;
      end else begin
         running_ff    <= running_in;
         sum_ff        <= sum_in;
         last_meas_ff  <= last_meas_in;
         last_time_ff  <= last_time_in;
         time_valid_ff <= time_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         mode_ff <= req_mode;
         meas_ff <= req_measurement;
         sp_ff   <= req_setpoint;
         now_ff  <= req_now_ms;
         init_ff <= req_initial_output;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (fire) begin
         drive_ff <= drive_in;
      end
   end

endmodule

// ===== rtl/pid_checker.sv =====
// ----------------------------------------------------------------------------
// pid_checker
// Port-level checks of the PID step, bound to the top level.
// ----------------------------------------------------------------------------
module pid_checker #(
   parameter int DATA_WIDTH = 32
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic signed [DATA_WIDTH-1:0] rsp_drive
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("result pending or input blocked after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_drive)))
      else $error("stalled result transaction changed");

   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without a transaction two cycles earlier");

   a_backpressure_only: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input blocked without a stalled result");

endmodule

bind pid_controller_step pid_checker #(.DATA_WIDTH(DATA_WIDTH)) u_pid_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_drive(rsp_drive)
);

// ===== bench/pid_controller_step_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_step_test
// Self-checking bench for the fixed-point PID step. A directed run covers the
// field extremes, every mode, the first-compute and wrapped time gates, crossed
// limits and limit writes while running. A pressure run under a long output
// hold-off follows, then random phases under changing gains, limits and sample
// periods with random idling on both sides. A scoreboard predicts each drive per transaction.
// ----------------------------------------------------------------------------
module pid_controller_step_test;
   import pid_pkg::*;

   localparam int HALF_PERIOD    = 5;
   localparam int RESET_CYCLES   = 7;
   localparam int SETTLE_CYCLES  = 4;
   localparam int TAIL_CYCLES    = 10;
   localparam int HOLD_CYCLES    = 300;
   localparam int PRESSURE_ITEMS = 40;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_ITEMS    = 70;
   localparam int MAX_PRINTS     = 40;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam logic signed [31:0] MIN_Q = 32'sh8000_0000;
   localparam logic signed [31:0] MAX_Q = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

   class pid_drive_tracker;
      localparam int FRAC = 16;
      localparam longint SUM_LIMIT = (longint'(1) << 47) - 1;

      logic [GAIN_W-1:0] gain_p;
      logic [GAIN_W-1:0] gain_i;
      logic [GAIN_W-1:0] gain_d;
      bit p_on_meas;
      bit reverse;
      longint out_min;
      longint out_max;
      logic [TIME_W-1:0] period;
      bit running;
      bit time_valid;
      longint loop_sum;
      longint last_meas;
      logic [TIME_W-1:0] last_time;
      logic signed [31:0] expected_drives[$];
      int mismatches;

      function new();
         gain_p = '0;
         gain_i = '0;
         gain_d = '0;
         p_on_meas = 1'b0;
         reverse = 1'b0;
         out_min = 0;
         out_max = longint'(DEFAULT_OUT_MAX) << FRAC;
         period = DEFAULT_PERIOD;
         running = 1'b0;
         time_valid = 1'b0;
         loop_sum = 0;
         last_meas = 0;
         last_time = '0;
         mismatches = 0;
      endfunction

      function int pending();
         return expected_drives.size();
      endfunction

      function longint saturate(longint x);
         if (x > SUM_LIMIT) return SUM_LIMIT;
         if (x < -SUM_LIMIT) return -SUM_LIMIT;
         return x;
      endfunction

      function longint limit(longint x);
         longint y;
         y = (x < out_max) ? x : out_max;
         return (y > out_min) ? y : out_min;
      endfunction

      // (a * g) >> FRAC on the magnitude, saturated, sign flipped when reverse acting
      function longint gain_term(longint a, logic [GAIN_W-1:0] g);
         bit neg;
         logic [63:0] mag;
         logic [63:0] q;
         neg = a < 0;
         mag = neg ? -a : a;
         q = (mag * 64'(g)) >> FRAC;
         if (q > $unsigned(SUM_LIMIT)) q = $unsigned(SUM_LIMIT);
         if (reverse) neg = !neg;
         return neg ? -longint'(q) : longint'(q);
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
         case (idx)
            CSR_GAIN_P: gain_p = value[GAIN_W-1:0];
            CSR_GAIN_I: gain_i = value[GAIN_W-1:0];
            CSR_GAIN_D: gain_d = value[GAIN_W-1:0];
            CSR_P_ON_MEAS: p_on_meas = value[0];
            CSR_REVERSE: reverse = value[0];
            CSR_OUT_MIN, CSR_OUT_MAX: begin
               if (idx == CSR_OUT_MIN) out_min = longint'($signed(value));
               else out_max = longint'($signed(value));
               if (running && out_min < out_max) loop_sum = limit(loop_sum);
            end
            CSR_SAMPLE_PERIOD: period = value;
            default: ;
         endcase
      endfunction

      function void note_request(logic [MODE_W-1:0] mode, logic signed [31:0] meas,
                                 logic signed [31:0] setpoint, logic [TIME_W-1:0] now,
                                 logic signed [31:0] init);
         longint err;
         longint delta;
         logic [TIME_W-1:0] elapsed;
         elapsed = now - last_time;
         case (mode)
            MODE_START: begin
               loop_sum = limit(longint'(init));
               last_meas = meas;
               running = 1'b1;
            end
            MODE_STOP: running = 1'b0;
            MODE_COMPUTE: begin
               if (running && (!time_valid || elapsed >= period)) begin
                  err = longint'(setpoint) - longint'(meas);
                  delta = longint'(meas) - last_meas;
                  loop_sum = saturate(loop_sum + gain_term(err, gain_i));
                  if (p_on_meas) loop_sum = saturate(loop_sum - gain_term(delta, gain_p));
                  else loop_sum = saturate(loop_sum + gain_term(err, gain_p));
                  loop_sum = limit(loop_sum);
                  loop_sum = saturate(loop_sum - gain_term(delta, gain_d));
                  expected_drives.push_back(32'(limit(loop_sum)));
                  last_meas = meas;
                  last_time = now;
                  time_valid = 1'b1;
               end
            end
            default: ;
         endcase
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= MAX_PRINTS) $display("MISMATCH at %0t: %s", $time, msg);
      endtask

      task check_drive(logic signed [31:0] drive);
         logic signed [31:0] want;
         if (expected_drives.size() == 0) begin
            report($sformatf("drive %h with no transaction waiting", drive));
         end else begin
            want = expected_drives.pop_front();
            if (drive !== want) report($sformatf("drive %h, expected %h", drive, want));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [MODE_W-1:0] req_mode = '0;
   logic signed [31:0] req_measurement = '0;
   logic signed [31:0] req_setpoint = '0;
   logic [TIME_W-1:0] req_now_ms = '0;
   logic signed [31:0] req_initial_output = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_drive;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   pid_drive_tracker tracker = new();

   int idle_pct = 0;
   int stall_pct = 0;
   int period_now = 0;
   logic [TIME_W-1:0] clock_ms = '0;
   event hold_off_go;
   bit hold_active = 1'b0;

   pid_controller_step uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_measurement    (req_measurement),
      .req_setpoint       (req_setpoint),
      .req_now_ms         (req_now_ms),
      .req_initial_output (req_initial_output),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_drive          (rsp_drive),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) tracker.write_reg(csr_index, csr_wdata);
         if (rsp_valid && rsp_ready) tracker.check_drive(rsp_drive);
         if (req_valid && req_ready) begin
            tracker.note_request(req_mode, req_measurement, req_setpoint, req_now_ms,
                                 req_initial_output);
         end
      end
   end

   // hold the output side off for a long stretch
   always begin
      @(hold_off_go);
      hold_active = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_active = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= !hold_active && ($urandom_range(99) >= stall_pct);
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) quiet = 0;
         else quiet++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic send(logic [MODE_W-1:0] mode, logic signed [31:0] meas,
                       logic signed [31:0] setpoint, logic [TIME_W-1:0] now,
                       logic signed [31:0] init);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_mode <= mode;
      req_measurement <= meas;
      req_setpoint <= setpoint;
      req_now_ms <= now;
      req_initial_output <= init;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // drop valid, drain every expected drive, then let the pipeline empty
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_reg(csr_index_type idx, logic [31:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [GAIN_W-1:0] pick_gain();
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         default: return GAIN_W'($urandom_range(0, 1 << 18));
      endcase
   endfunction

   function automatic logic signed [31:0] pick_value();
      logic signed [31:0] v;
      case ($urandom_range(9))
         0: v = $urandom;
         1: v = $urandom_range(1) ? MIN_Q : MAX_Q;
         2: v = $urandom_range(1) ? 32'sd0 : -32'sd1;
         default: begin
            v = $urandom_range(0, 1 << 25);
            v = v - (1 << 24);
         end
      endcase
      return v;
   endfunction

   task automatic run_directed();
      idle_pct = 0;
      stall_pct = 0;
      send(MODE_COMPUTE, 0, 0, 0, 0);
      send(MODE_UNUSED, -1, -1, '1, -1);
      send(MODE_STOP, 0, 0, 0, 0);
      send(MODE_START, MAX_Q, 0, 0, MAX_Q);
      send(MODE_COMPUTE, 0, 0, 32'hFFFF_FFF0, 0);
      send(MODE_COMPUTE, 0, 0, 32'h0000_0050, 0);
      send(MODE_START, 0, 0, 0, MIN_Q);
      send(MODE_COMPUTE, 0, 0, 32'h0000_0054, 0);
      settle();
      set_reg(CSR_GAIN_P, '1);
      set_reg(CSR_GAIN_I, '1);
      set_reg(CSR_GAIN_D, 32'h7FFF_FFFF);
      set_reg(CSR_OUT_MIN, MIN_Q);
      set_reg(CSR_OUT_MAX, MAX_Q);
      set_reg(CSR_SAMPLE_PERIOD, 0);
      send(MODE_COMPUTE, MIN_Q, MAX_Q, 1, 0);
      send(MODE_COMPUTE, MAX_Q, MIN_Q, 2, 0);
      send(MODE_COMPUTE, 0, 0, 2, 0);
      settle();
      set_reg(CSR_P_ON_MEAS, 1);
      set_reg(CSR_REVERSE, 1);
      send(MODE_COMPUTE, 12345, -999999, 3, 0);
      send(MODE_COMPUTE, -7, MAX_Q, 4, 0);
      settle();
      set_reg(CSR_GAIN_P, Q_ONE);
      set_reg(CSR_GAIN_I, Q_ONE >>> 1);
      set_reg(CSR_GAIN_D, Q_ONE >>> 2);
      set_reg(CSR_P_ON_MEAS, 0);
      set_reg(CSR_REVERSE, 0);
      set_reg(CSR_OUT_MIN, -(100 * Q_ONE));
      set_reg(CSR_OUT_MAX, 100 * Q_ONE);
      send(MODE_COMPUTE, Q_ONE, 2 * Q_ONE, 5, 0);
      send(MODE_COMPUTE, -Q_ONE, 3 * Q_ONE, 6, 0);
      settle();
      set_reg(CSR_OUT_MIN, 5 * Q_ONE);
      set_reg(CSR_OUT_MAX, -(5 * Q_ONE));
      send(MODE_COMPUTE, 0, Q_ONE, 7, 0);
      send(MODE_STOP, 0, 0, 8, 0);
      send(MODE_COMPUTE, 0, Q_ONE, 8, 0);
      send(MODE_START, Q_ONE, 0, 9, 7 * Q_ONE);
      send(MODE_COMPUTE, Q_ONE, 0, 10, 0);
      settle();
      set_reg(CSR_OUT_MIN, -(20 * Q_ONE));
      set_reg(CSR_OUT_MAX, 2 * Q_ONE);
      set_reg(CSR_SAMPLE_PERIOD, '1);
      send(MODE_COMPUTE, Q_ONE, Q_ONE, 9, 0);
      send(MODE_COMPUTE, Q_ONE, Q_ONE, 15, 0);
   endtask

   task automatic run_pressure();
      idle_pct = 0;
      stall_pct = 0;
      settle();
      period_now = 0;
      set_reg(CSR_SAMPLE_PERIOD, period_now);
      set_reg(CSR_OUT_MIN, MIN_Q);
      set_reg(CSR_OUT_MAX, MAX_Q);
      send(MODE_START, 0, 0, clock_ms, 0);
      -> hold_off_go;
      repeat (PRESSURE_ITEMS) begin
         clock_ms += 1;
         send(MODE_COMPUTE, pick_value(), pick_value(), clock_ms, 0);
      end
   endtask

   task automatic program_setting();
      logic signed [31:0] lo;
      logic signed [31:0] hi;
      set_reg(CSR_GAIN_P, {1'($urandom), pick_gain()});
      set_reg(CSR_GAIN_I, {1'($urandom), pick_gain()});
      set_reg(CSR_GAIN_D, {1'($urandom), pick_gain()});
      set_reg(CSR_P_ON_MEAS, {31'($urandom), 1'($urandom)});
      set_reg(CSR_REVERSE, {31'($urandom), 1'($urandom)});
      case ($urandom_range(7))
         0: begin
            lo = MIN_Q;
            hi = MAX_Q;
         end
         1: begin
            lo = pick_value();
            hi = pick_value();
         end
         2: begin
            lo = pick_value();
            hi = lo;
         end
         default: begin
            lo = $urandom_range(0, 1 << 26);
            lo = -lo;
            hi = $urandom_range(1, 1 << 26);
         end
      endcase
      set_reg(CSR_OUT_MIN, lo);
      set_reg(CSR_OUT_MAX, hi);
      case ($urandom_range(5))
         0: period_now = 0;
         1: period_now = 1;
         default: period_now = $urandom_range(2, 60);
      endcase
      set_reg(CSR_SAMPLE_PERIOD, period_now);
   endtask

   task automatic send_random_item();
      logic signed [31:0] sp;
      logic signed [31:0] meas;
      logic signed [31:0] offs;
      int pick;
      pick = $urandom_range(99);
      sp = pick_value();
      meas = pick_value();
      if (pick < 5) begin
         send(MODE_START, meas, sp, clock_ms, pick_value());
      end else if (pick < 8) begin
         send(MODE_STOP, meas, sp, clock_ms, pick_value());
      end else if (pick < 11) begin
         send(MODE_UNUSED, meas, sp, $urandom, pick_value());
      end else begin
         if ($urandom_range(29) == 0) clock_ms = $urandom;
         else clock_ms += $urandom_range(0, 2 * period_now + 2);
         if ($urandom_range(4) != 0) begin
            offs = $urandom_range(0, 1 << 19);
            meas = sp + offs - (1 << 18);
         end
         send(MODE_COMPUTE, meas, sp, clock_ms, pick_value());
      end
   endtask

   task automatic run_random_phase(int phase);
      settle();
      case (phase % 4)
         0: begin
            idle_pct = 0;
            stall_pct = 0;
         end
         1: begin
            idle_pct = 48;
            stall_pct = 0;
         end
         2: begin
            idle_pct = 0;
            stall_pct = 48;
         end
         default: begin
            idle_pct = 8;
            stall_pct = 8;
         end
      endcase
      program_setting();
      send(MODE_START, pick_value(), 0, clock_ms, pick_value());
      repeat (PHASE_ITEMS) send_random_item();
   endtask

   initial begin : main_flow
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      run_directed();
      run_pressure();
      for (int p = 0; p < RANDOM_PHASES; p++) run_random_phase(p);
      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/pid_pkg.sv
rtl/pid_term.sv
rtl/pid_controller_step.sv
rtl/pid_checker.sv
bench/pid_controller_step_test.sv
